### src/mccp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mccp_pkg
// Types, constants and the exp table for the call payoff accumulator.
// ----------------------------------------------------------------------------
package mccp_pkg;

    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int EXP_LOG2 = $clog2(EXP_TABLE_ENTRIES);
    localparam int FRAC_W = 28 - EXP_LOG2;       // fraction bits below table index
    localparam int U_W = 30 - EXP_LOG2;          // width of polynomial argument u

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [27:0] LOG2E_Q27 = 28'd193635251;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;
    localparam logic signed [36:0] X_LIMIT = 37'sd12348030976;

    // config register indexes
    localparam logic [2:0] REG_SPOT = 3'd0;
    localparam logic [2:0] REG_STRIKE = 3'd1;
    localparam logic [2:0] REG_DRIFT = 3'd2;
    localparam logic [2:0] REG_VOL = 3'd3;
    localparam logic [2:0] REG_DISC = 3'd4;

    typedef struct packed {
        logic [31:0]        spot;
        logic [31:0]        strike;
        logic signed [31:0] drift;
        logic [30:0]        vol;
        logic [31:0]        disc;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] z;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               full;
    } t_q_stat;

    typedef logic [31:0] t_exp_table [EXP_TABLE_ENTRIES];

    // Q.30 Taylor series of exp(i*ln2/N), each term floored
    function automatic t_exp_table build_exp_table();
        t_exp_table tbl;
        longint unsigned v;
        longint unsigned term;
        longint unsigned sum;
        for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
            v = (longint'(i) * 64'd744261118) / EXP_TABLE_ENTRIES;
            term = 64'd1073741824;
            sum = term;
            term = ((term * v) >> 30) / 1;  sum = sum + term;
            term = ((term * v) >> 30) / 2;  sum = sum + term;
            term = ((term * v) >> 30) / 3;  sum = sum + term;
            term = ((term * v) >> 30) / 4;  sum = sum + term;
            term = ((term * v) >> 30) / 5;  sum = sum + term;
            term = ((term * v) >> 30) / 6;  sum = sum + term;
            term = ((term * v) >> 30) / 7;  sum = sum + term;
            term = ((term * v) >> 30) / 8;  sum = sum + term;
            term = ((term * v) >> 30) / 9;  sum = sum + term;
            term = ((term * v) >> 30) / 10; sum = sum + term;
            term = ((term * v) >> 30) / 11; sum = sum + term;
            term = ((term * v) >> 30) / 12; sum = sum + term;
            tbl[i] = sum[31:0];
        end
        return tbl;
    endfunction

    localparam t_exp_table EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

### src/mccp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mccp_front
// Input side: takes sample words into a short queue for the back end.
// ----------------------------------------------------------------------------
module mccp_front
    import mccp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_s_valid,
    output logic        o_s_ready,
    input  wire t_item  i_s_item,
    output logic        o_d_valid,
    input  wire logic   i_d_ready,
    output t_item       o_d_item,
    output t_q_stat     o_stat
);

    t_item              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               push, pop;

    assign o_s_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_d_valid = (r_cnt != '0);
    assign o_d_item = r_q[r_rd];
    assign push = i_s_valid && o_s_ready;
    assign pop = o_d_valid && i_d_ready;
    assign o_stat.count = r_cnt;
    assign o_stat.full = !o_s_ready;

    always_comb begin
        n_wr = push ? r_wr + 1'b1 : r_wr;
        n_rd = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_s_item;
        end
    end

endmodule
`default_nettype wire

### src/mccp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mccp_back
// Sequencer: price path, payoff accumulation and discounted batch result.
// ----------------------------------------------------------------------------
module mccp_back
    import mccp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_d_valid,
    output logic        o_d_ready,
    input  wire t_item  i_d_item,
    output logic        o_m_valid,
    input  wire logic   i_m_ready,
    output logic [63:0] o_m_sum,
    output logic [31:0] o_m_count,
    output logic        o_m_ovf
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MULZ  = 13'b0000000000010,
        S_CLAMP = 13'b0000000000100,
        S_MY1   = 13'b0000000001000,
        S_MY2   = 13'b0000000010000,
        S_MU    = 13'b0000000100000,
        S_POLY  = 13'b0000001000000,
        S_MTAB  = 13'b0000010000000,
        S_SPOT  = 13'b0000100000000,
        S_ACC   = 13'b0001000000000,
        S_DHI   = 13'b0010000000000,
        S_DLO   = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } t_state;

    t_state              r_state, n_state;
    logic signed [15:0]  r_z;
    logic                r_last;
    logic signed [47:0]  r_a;
    logic signed [34:0]  r_x;
    logic [43:0]         r_b;
    logic signed [35:0]  r_y;
    logic [U_W-1:0]      r_u;
    logic [31:0]         r_poly;
    logic [31:0]         r_m;
    logic [63:0]         r_prod;
    logic [63:0]         r_sum;
    logic [31:0]         r_cnt;
    logic                r_sat;
    logic [63:0]         r_dh, r_dl;
    logic                r_ovalid;

    // datapath terms
    logic signed [47:0]  a_sh;
    logic signed [36:0]  x_full;
    logic signed [47:0]  ph;
    logic signed [63:0]  ysum;
    logic [FRAC_W+29:0]  ul;
    logic [2*U_W-1:0]    uu;
    logic [63:0]         tp;
    logic signed [7:0]   k;
    logic signed [7:0]   s_dn;
    logic [5:0]          s_up;
    logic [63:0]         sh;
    logic                ovf_px;
    logic [63:0]         price;
    logic [63:0]         payoff;
    logic [64:0]         sum_ext;
    logic                load_out;

    assign o_d_ready = (r_state == S_IDLE);
    assign o_m_valid = r_ovalid;
    assign load_out = (r_state == S_EMIT) && (!r_ovalid || i_m_ready);

    always_comb begin
        a_sh = r_a >>> 12;
        x_full = {{5{i_cfg.drift[31]}}, i_cfg.drift} + a_sh[36:0];
        ph = $signed(r_x[34:16]) * $signed({1'b0, LOG2E_Q27});
        ysum = ({{16{ph[47]}}, ph} <<< 16) + $signed({20'b0, r_b});
        ul = r_y[FRAC_W-1:0] * LN2_Q30;
        uu = r_u * r_u;
        tp = EXP_TABLE[r_y[27:FRAC_W]] * r_poly;
        k = r_y[35:28];
        s_up = 6'(k - 8'sd30);
        s_dn = 8'sd30 - k;
        sh = r_prod << s_up;
        ovf_px = 1'b0;
        if (k >= 8'sd30) begin
            price = sh;
            ovf_px = ((sh >> s_up) != r_prod);
        end else if (s_dn >= 8'sd64) begin
            price = '0;
        end else begin
            price = r_prod >> s_dn[5:0];
        end
        if (ovf_px) begin
            payoff = '1;
        end else if (price > {32'b0, i_cfg.strike}) begin
            payoff = price - {32'b0, i_cfg.strike};
        end else begin
            payoff = '0;
        end
        sum_ext = {1'b0, r_sum} + {1'b0, payoff};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_d_valid) n_state = S_MULZ;
            S_MULZ:  n_state = S_CLAMP;
            S_CLAMP: n_state = S_MY1;
            S_MY1:   n_state = S_MY2;
            S_MY2:   n_state = S_MU;
            S_MU:    n_state = S_POLY;
            S_POLY:  n_state = S_MTAB;
            S_MTAB:  n_state = S_SPOT;
            S_SPOT:  n_state = S_ACC;
            S_ACC:   n_state = r_last ? S_DHI : S_IDLE;
            S_DHI:   n_state = S_DLO;
            S_DLO:   n_state = S_EMIT;
            S_EMIT:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum <= '0;
            r_cnt <= '0;
            r_sat <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                if (sum_ext[64]) begin
                    r_sum <= '1;
                end else begin
                    r_sum <= sum_ext[63:0];
                end
                if (sum_ext[64] || ovf_px) r_sat <= 1'b1;
                if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
            end
            if (load_out) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_sat <= 1'b0;
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_d_ready && i_d_valid) begin
            r_z <= i_d_item.z;
            r_last <= i_d_item.last;
        end
        if (r_state == S_MULZ) r_a <= $signed({1'b0, i_cfg.vol}) * r_z;
        if (r_state == S_CLAMP) begin
            if (x_full > X_LIMIT) r_x <= X_LIMIT[34:0];
            else if (x_full < -X_LIMIT) r_x <= 35'(-X_LIMIT);
            else r_x <= x_full[34:0];
        end
        if (r_state == S_MY1) r_b <= r_x[15:0] * LOG2E_Q27;
        if (r_state == S_MY2) r_y <= ysum[62:27];
        if (r_state == S_MU) r_u <= ul[FRAC_W+29:28];
        if (r_state == S_POLY) r_poly <= ONE_Q30 + 32'(r_u) + 32'(uu >> 31);
        if (r_state == S_MTAB) r_m <= tp[61:30];
        if (r_state == S_SPOT) r_prod <= i_cfg.spot * r_m;
        if (r_state == S_DHI) r_dh <= r_sum[63:32] * i_cfg.disc;
        if (r_state == S_DLO) r_dl <= r_sum[31:0] * i_cfg.disc;
        if (load_out) begin
            o_m_sum <= r_dh + {32'b0, r_dl[63:32]};
            o_m_count <= r_cnt;
            o_m_ovf <= r_sat;
        end
    end

endmodule
`default_nettype wire

### src/monte_carlo_call_payoff_accumulator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// monte_carlo_call_payoff_accumulator_top
// Black-Scholes Monte Carlo European call: payoff sum per batch of samples.
// ----------------------------------------------------------------------------
// Each slave word is one standard normal draw (Q4.12); tlast closes a batch.
// Per word the block forms spot*exp(drift + vol*z), takes the call payoff
// against the strike and adds it to a saturating 64-bit sum. On a tlast word
// one master word comes out: the sum times the discount factor (Q48.16), the
// sample count and, in tuser, a flag set if the sum or a price saturated.
// A word steps through the back-end sequencer states (at most one multiply per
// step), and a batch end adds the two discount product states and the output
// load; a four-word queue lets the source run ahead.
// The result register holds one finished word, so later samples keep flowing
// while it waits. Config writes go through i_cfg_we/i_cfg_addr/i_cfg_data and
// must only happen while the block is idle.
// ----------------------------------------------------------------------------
module monte_carlo_call_payoff_accumulator_top
    import mccp_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // config write port
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_addr,
    input  wire logic [31:0]   i_cfg_data,
    // sample stream
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [15:0]   i_s_axis_tdata,   // [15:0] normal_sample
    input  wire logic          i_s_axis_tlast,   // last_sample
    // result stream
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [95:0]        o_m_axis_tdata,   // [63:0] discounted_sum, [95:64] sample_count
    output logic               o_m_axis_tuser    // [0] sum_overflow
);

    t_cfg    r_cfg;
    t_item   s_item, d_item;
    logic    d_valid, d_ready;
    t_q_stat q_stat;
    logic [63:0] m_sum;
    logic [31:0] m_cnt;

    // config registers, reset to the nominal market set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spot <= 32'd6553600;
            r_cfg.strike <= 32'd7208960;
            r_cfg.drift <= 32'sd10737418;
            r_cfg.vol <= 31'd53687091;
            r_cfg.disc <= 32'd4044847877;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SPOT:   r_cfg.spot <= i_cfg_data;
                REG_STRIKE: r_cfg.strike <= i_cfg_data;
                REG_DRIFT:  r_cfg.drift <= $signed(i_cfg_data);
                REG_VOL:    r_cfg.vol <= i_cfg_data[30:0];
                REG_DISC:   r_cfg.disc <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign s_item.z = $signed(i_s_axis_tdata);
    assign s_item.last = i_s_axis_tlast;

    mccp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_item  (s_item),
        .o_d_valid (d_valid),
        .i_d_ready (d_ready),
        .o_d_item  (d_item),
        .o_stat    (q_stat)
    );

    mccp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_d_valid (d_valid),
        .o_d_ready (d_ready),
        .i_d_item  (d_item),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_sum   (m_sum),
        .o_m_count (m_cnt),
        .o_m_ovf   (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {m_cnt, m_sum};

`ifndef SYNTHESIS
    // queue never holds more than its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= Q_CNT_W'(Q_DEPTH))
        else $error("sample queue over depth");

    // backpressure on the slave side only when the queue is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> q_stat.full)
        else $error("tready low with queue space");

    // a word pushed into an empty queue is visible to the back end next cycle
    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && q_stat.count == '0 && !d_valid)
        |=> d_valid)
        else $error("queued word lost");
`endif

endmodule
`default_nettype wire

### sim/tb_monte_carlo_call_payoff_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_monte_carlo_call_payoff_accumulator_top
// Self-checking bench for the Monte Carlo call payoff accumulator.
// ----------------------------------------------------------------------------
// Normal samples are streamed in batches. A bit-exact price and payoff model
// in the bench keeps its own running sum and predicts every batch word.
// Directed cases cover field extremes, price and sum saturation, and zero
// prices. Random batches follow under several register settings, with random
// source and sink stalls and one long sink hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_monte_carlo_call_payoff_accumulator_top;
    import mccp_pkg::*;

    localparam int  LIMIT_CYCLES = 1000000;
    localparam int  SETTLE_CYCLES = 40;     // longer than the batch-end path through the sequencer

    typedef struct {
        logic [63:0] disc_sum;
        logic [31:0] count;
        logic        ovf;
    } t_batch_word;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;

    // model copy of the registers
    logic [31:0] spot_q = 32'd6553600;
    logic [31:0] strike_q = 32'd7208960;
    logic signed [31:0] drift_q = 32'sd10737418;
    logic [30:0] vol_q = 31'd53687091;
    logic [31:0] disc_q = 32'd4044847877;

    // model batch state
    logic [63:0] run_sum = '0;
    logic [31:0] run_count = '0;
    logic        run_sat = 1'b0;

    longint unsigned pow2_frac [EXP_TABLE_ENTRIES];
    t_batch_word     pending_batches [$];

    int  errors = 0;
    int  src_idle_pct = 0;
    int  dst_idle_pct = 0;
    int  hold_left = 0;
    longint cycles = 0;

    monte_carlo_call_payoff_accumulator_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [15:0] normal_sample
        .i_s_axis_tlast  (s_tlast),    // last_sample
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [63:0] discounted_sum, [95:64] sample_count
        .o_m_axis_tuser  (m_tuser)     // [0] sum_overflow
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // sink side: random stalls, plus a counted hold-off on request
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // result checker: oldest expectation first
    always @(posedge clk) begin
        t_batch_word want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_batches.size() == 0) begin
                errors++;
                $display("%0t: unexpected word sum=%h cnt=%0d ovf=%b", $time,
                         m_tdata[63:0], m_tdata[95:64], m_tuser);
            end else begin
                want = pending_batches.pop_front();
                if (m_tdata[63:0] !== want.disc_sum) begin
                    errors++;
                    $display("%0t: discounted_sum exp %h got %h", $time,
                             want.disc_sum, m_tdata[63:0]);
                end
                if (m_tdata[95:64] !== want.count) begin
                    errors++;
                    $display("%0t: sample_count exp %0d got %0d", $time,
                             want.count, m_tdata[95:64]);
                end
                if (m_tuser !== want.ovf) begin
                    errors++;
                    $display("%0t: sum_overflow exp %b got %b", $time,
                             want.ovf, m_tuser);
                end
            end
        end
    end

    // 2^(i/N) in Q.30, truncated Taylor series of exp(i*ln2/N)
    task automatic fill_pow2_table();
        longint unsigned arg, term, acc;
        for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
            arg = (longint'(i) * 64'd744261118) / EXP_TABLE_ENTRIES;
            term = 64'd1073741824;
            acc = term;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * arg) >> 30) / n;
                acc += term;
            end
            pow2_frac[i] = acc;
        end
    endtask

    // spot * exp(x), Q16.16; saturates when it does not fit 64 bits
    function automatic logic [63:0] asset_price(input longint x, output bit sat);
        longint y, k, sh;
        longint unsigned frac, idx, dn, u, poly, mant, prod;
        sat = 1'b0;
        if (x > 64'sd12348030976) x = 64'sd12348030976;
        if (x < -64'sd12348030976) x = -64'sd12348030976;
        y = (x * 64'sd193635251) >>> 27;
        k = y >>> 28;
        frac = y - (k <<< 28);
        idx = (frac * EXP_TABLE_ENTRIES) >> 28;
        if (idx >= EXP_TABLE_ENTRIES) idx = EXP_TABLE_ENTRIES - 1;
        dn = frac * EXP_TABLE_ENTRIES - (idx << 28);
        u = ((dn * 64'd744261118) / EXP_TABLE_ENTRIES) >> 28;
        poly = 64'd1073741824 + u + ((u * u) >> 31);
        mant = (pow2_frac[idx] * poly) >> 30;
        prod = longint'(spot_q) * mant;
        if (prod == 0) return 64'd0;
        if (k >= 30) begin
            sh = k - 30;
            if (sh == 0) return prod;
            if (sh >= 64 || (prod >> (64 - sh)) != 0) begin
                sat = 1'b1;
                return '1;
            end
            return prod << sh;
        end
        sh = 30 - k;
        if (sh >= 64) return 64'd0;
        return prod >> sh;
    endfunction

    // fold one accepted sample into the model batch
    task automatic accumulate_sample(input logic signed [15:0] z, input bit last);
        longint x;
        bit sat;
        logic [63:0] price, payoff;
        t_batch_word w;
        x = longint'(drift_q) + ((longint'(vol_q) * longint'(z)) >>> 12);
        price = asset_price(x, sat);
        if (sat) payoff = '1;
        else payoff = (price > strike_q) ? price - strike_q : 64'd0;
        if (payoff > ~run_sum) begin
            run_sum = '1;
            run_sat = 1'b1;
        end else begin
            run_sum += payoff;
        end
        if (sat) run_sat = 1'b1;
        if (run_count != '1) run_count++;
        if (last) begin
            w.disc_sum = (run_sum >> 32) * disc_q
                       + (((run_sum & 64'hFFFF_FFFF) * disc_q) >> 32);
            w.count = run_count;
            w.ovf = run_sat;
            pending_batches.push_back(w);
            run_sum = '0;
            run_count = '0;
            run_sat = 1'b0;
        end
    endtask

    // one word on the sample stream; entered and left at a falling edge
    task automatic send_sample(input logic [15:0] z, input bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = z;
        s_tlast = last;
        do @(posedge clk); while (!s_tready);
        accumulate_sample(z, last);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_batches.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_SPOT:   spot_q = val;
            REG_STRIKE: strike_q = val;
            REG_DRIFT:  drift_q = val;
            REG_VOL:    vol_q = val[30:0];
            REG_DISC:   disc_q = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [31:0] spot, input logic [31:0] strike,
                             input logic [31:0] drift, input logic [31:0] vol,
                             input logic [31:0] disc);
        drain();
        write_reg(REG_SPOT, spot);
        write_reg(REG_STRIKE, strike);
        write_reg(REG_DRIFT, drift);
        write_reg(REG_VOL, vol);
        write_reg(REG_DISC, disc);
    endtask

    // mostly near-normal draws, sometimes anything in the field
    function automatic logic [15:0] draw_sample();
        if ($urandom_range(9) < 7)
            return 16'($signed($urandom_range(24576)) - 12288);
        return 16'($urandom());
    endfunction

    task automatic random_batches(input int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
            for (int j = 1; j <= len; j++)
                send_sample(draw_sample(), j == len);
            sent += len;
        end
    endtask

    task automatic test_reset_values();
        send_sample(16'h0000, 1'b1);
        send_sample(16'h7FFF, 1'b0);          // largest positive draw
        send_sample(16'h8000, 1'b0);          // most negative draw
        send_sample(16'h1000, 1'b1);
    endtask

    task automatic test_price_saturation();
        // huge drift and vol: price overflows 64 bits, sum saturates
        load_regs(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        // large but representable prices from a high spot and drift, zero vol
        load_regs(32'hFFFF_FFFF, 32'h0, 32'h1C00_0000, 32'h0, 32'hFFFF_FFFF);
        send_sample(16'h1234, 1'b0);
        send_sample(16'h4321, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0001, 1'b1);
    endtask

    task automatic test_zero_and_floor();
        // zero spot, strike and discount, most negative drift, vol at its top
        load_regs(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        load_regs(32'h0064_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000);
        send_sample(16'h5555, 1'b1);
        load_regs(32'h0064_0000, 32'h0, 32'h0, 32'h1000_0000, 32'h8000_0000);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'h8000, 1'b1);
    endtask

    task automatic test_random_phase(input int n_configs, input int per_config);
        logic [31:0] spot;
        for (int c = 0; c < n_configs; c++) begin
            spot = $urandom_range(32'h0400_0000, 32'h0001_0000);
            load_regs(spot, spot + $urandom_range(32'h0080_0000) - 32'h0040_0000,
                      32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000),
                      $urandom_range(32'h2000_0000),
                      $urandom_range(32'hFFFF_FFFF, 32'hC000_0000));
            random_batches(per_config);
        end
    endtask

    task automatic test_backpressure();
        load_regs(32'h0064_0000, 32'h0060_0000, 32'h0, 32'h0400_0000, 32'hF000_0000);
        src_idle_pct = 0;
        hold_left = 400;      // sink stalls while batches keep coming
        for (int j = 0; j < 40; j++)
            send_sample(draw_sample(), (j % 3) == 2);
    endtask

    initial begin
        fill_pow2_table();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        src_idle_pct = 20;
        dst_idle_pct = 20;
        test_reset_values();
        test_price_saturation();
        test_zero_and_floor();

        src_idle_pct = 36;
        dst_idle_pct = 69;
        test_random_phase(4, 150);
        src_idle_pct = 69;
        dst_idle_pct = 36;
        test_random_phase(4, 150);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_phase(4, 150);
        test_backpressure();

        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
